// ----- rtl/cktrk_pkg.sv -----
// ----------------------------------------------------------------------------
// cktrk_pkg: shared types and constants for the cursor key mode tracker
// Byte codes, match phases, key sequence beats and the item/status structs.
// ----------------------------------------------------------------------------
package cktrk_pkg;

  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_LBRKT  = 8'h5b;  // '['
  localparam logic [7:0] CH_QMARK  = 8'h3f;  // '?'
  localparam logic [7:0] CH_SEMI   = 8'h3b;  // ';'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_SET    = 8'h68;  // 'h'
  localparam logic [7:0] CH_RESET  = 8'h6c;  // 'l'
  localparam logic [7:0] CH_SS3    = 8'h4f;  // 'O'
  localparam logic [7:0] CH_FIN_LO = 8'h40;
  localparam logic [7:0] CH_FIN_HI = 8'h7e;
  localparam logic [7:0] CH_UP     = 8'h41;  // 'A'
  localparam logic [7:0] CH_DOWN   = 8'h42;  // 'B'
  localparam logic [7:0] CH_RIGHT  = 8'h43;  // 'C'
  localparam logic [7:0] CH_LEFT   = 8'h44;  // 'D'

  localparam logic [3:0] PARAM_MAX = 4'd15;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_ARROW = 1'b1;

  localparam logic [1:0] KEY_UP    = 2'd0;
  localparam logic [1:0] KEY_DOWN  = 2'd1;
  localparam logic [1:0] KEY_LEFT  = 2'd2;
  localparam logic [1:0] KEY_RIGHT = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_CSI   = 2'd2,
    PH_PARAM = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BEAT_ESC   = 2'd0,
    BEAT_INTRO = 2'd1,
    BEAT_FINAL = 2'd2
  } beat_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic [1:0] arrow_key;
  } item_t;

  typedef struct packed {
    logic app_cursor;      // mode before the current item
    logic app_cursor_nxt;  // mode after the current item if it is a byte
  } mode_status_t;

  function automatic logic [7:0] key_final(input logic [1:0] key);
    logic [7:0] ch;
    case (key)
      KEY_UP:    ch = CH_UP;
      KEY_DOWN:  ch = CH_DOWN;
      KEY_LEFT:  ch = CH_LEFT;
      KEY_RIGHT: ch = CH_RIGHT;
      default:   ch = CH_UP;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/cktrk_parser.sv -----
// ----------------------------------------------------------------------------
// cktrk_parser: private-mode sequence matcher
// Tracks ESC [ ? params h/l in the output stream and holds the cursor mode.
// ----------------------------------------------------------------------------
module cktrk_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    commit,
  input  cktrk_pkg::item_t        item,
  output cktrk_pkg::mode_status_t status
);
  import cktrk_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] param_r, param_nxt;
  logic       digits_r, digits_nxt;
  logic       one_seen_r, one_seen_nxt;
  logic       app_cursor_r, app_cursor_nxt;

  logic [7:0] ch;
  logic [7:0] accum;
  logic       close_one;
  logic       is_byte;

  assign ch      = item.data_byte;
  assign is_byte = (item.op == OP_BYTE);

  always_comb begin
    accum     = {4'd0, param_r} * 8'd10 + (ch - CH_ZERO);
    close_one = digits_r && (param_r == 4'd1);

    phase_nxt      = phase_r;
    param_nxt      = param_r;
    digits_nxt     = digits_r;
    one_seen_nxt   = one_seen_r;
    app_cursor_nxt = app_cursor_r;

    if (is_byte) begin
      if (ch == CH_ESC) begin
        phase_nxt = PH_ESC;
      end else begin
        case (phase_r)
          PH_ESC: begin
            phase_nxt = (ch == CH_LBRKT) ? PH_CSI : PH_IDLE;
          end
          PH_CSI: begin
            if (ch == CH_QMARK) begin
              phase_nxt    = PH_PARAM;
              param_nxt    = 4'd0;
              digits_nxt   = 1'b0;
              one_seen_nxt = 1'b0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_PARAM: begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
              param_nxt  = (accum > {4'd0, PARAM_MAX}) ? PARAM_MAX : accum[3:0];
              digits_nxt = 1'b1;
            end else if (ch == CH_SEMI) begin
              one_seen_nxt = one_seen_r | close_one;
              param_nxt    = 4'd0;
              digits_nxt   = 1'b0;
            end else if (ch == CH_SET || ch == CH_RESET) begin
              one_seen_nxt = one_seen_r | close_one;
              if (one_seen_r || close_one) begin
                app_cursor_nxt = (ch == CH_SET);
              end
              phase_nxt = PH_IDLE;
            end else if (ch >= CH_FIN_LO && ch <= CH_FIN_HI) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      param_r      <= 4'd0;
      digits_r     <= 1'b0;
      one_seen_r   <= 1'b0;
      app_cursor_r <= 1'b0;
    end else if (commit) begin
      phase_r      <= phase_nxt;
      param_r      <= param_nxt;
      digits_r     <= digits_nxt;
      one_seen_r   <= one_seen_nxt;
      app_cursor_r <= app_cursor_nxt;
    end
  end

  assign status.app_cursor     = app_cursor_r;
  assign status.app_cursor_nxt = app_cursor_nxt;

  // Only a committed output byte may move the mode.
  a_mode_only_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    !(commit && is_byte) |=> $stable(app_cursor_r))
    else $error("cursor mode changed without a committed byte");

  a_esc_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    commit && is_byte && ch == CH_ESC |=> phase_r == PH_ESC)
    else $error("ESC did not restart matching");

  // Key presses leave the stream matcher alone.
  a_arrow_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    commit && !is_byte |=> $stable(phase_r) && $stable(param_r))
    else $error("arrow key disturbed sequence state");

endmodule

// ----- rtl/cktrk_emit.sv -----
// ----------------------------------------------------------------------------
// cktrk_emit: result register and key sequence sequencer
// Holds one result; an arrow key plays out as three beats from this register.
// ----------------------------------------------------------------------------
module cktrk_emit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  cktrk_pkg::item_t        item,
  input  cktrk_pkg::mode_status_t status,
  output logic                    load_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_out_byte,
  output logic                    out_out_valid,
  output logic                    out_last,
  output logic                    out_app_cursor_mode
);
  import cktrk_pkg::*;

  logic       valid_r;
  logic       arrow_r;
  beat_t      beat_r, beat_nxt;
  logic [1:0] key_r;
  logic       mode_r;
  logic       last_beat;
  logic       xfer;

  assign last_beat  = !arrow_r || (beat_r == BEAT_FINAL);
  assign xfer       = valid_r && out_ready;
  assign load_ready = !valid_r || (out_ready && last_beat);

  always_comb begin
    case (beat_r)
      BEAT_ESC:   beat_nxt = BEAT_INTRO;
      BEAT_INTRO: beat_nxt = BEAT_FINAL;
      BEAT_FINAL: beat_nxt = BEAT_FINAL;
      default:    beat_nxt = BEAT_ESC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      arrow_r <= 1'b0;
      beat_r  <= BEAT_ESC;
    end else if (load) begin
      valid_r <= 1'b1;
      arrow_r <= (item.op == OP_ARROW);
      beat_r  <= BEAT_ESC;
    end else if (xfer) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_nxt;
      end
    end
  end

  // Arrow keys report the mode in force; bytes report the mode they leave.
  always_ff @(posedge clk) begin
    if (load) begin
      key_r  <= item.arrow_key;
      mode_r <= (item.op == OP_ARROW) ? status.app_cursor : status.app_cursor_nxt;
    end
  end

  always_comb begin
    if (!arrow_r) begin
      out_out_byte = 8'd0;
    end else begin
      case (beat_r)
        BEAT_ESC:   out_out_byte = CH_ESC;
        BEAT_INTRO: out_out_byte = mode_r ? CH_SS3 : CH_LBRKT;
        BEAT_FINAL: out_out_byte = key_final(key_r);
        default:    out_out_byte = 8'd0;
      endcase
    end
  end

  assign out_valid           = valid_r;
  assign out_out_valid       = arrow_r;
  assign out_last            = last_beat;
  assign out_app_cursor_mode = mode_r;

  a_byte_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !arrow_r |-> beat_r == BEAT_ESC)
    else $error("byte result off its first beat");

  a_beat_advance: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !last_beat |=> valid_r && arrow_r && beat_r == beat_t'($past(beat_r) + 2'd1))
    else $error("key sequence beat skipped or dropped");

  a_no_load_midseq: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !last_beat |-> !load)
    else $error("new item loaded during key sequence");

endmodule

// ----- rtl/cursor_key_mode_tracker.sv -----
// ----------------------------------------------------------------------------
// cursor_key_mode_tracker: DECCKM cursor key mode tracker and arrow encoder
// Follows ESC [ ? ... h/l in terminal output and encodes arrow key presses.
// ----------------------------------------------------------------------------
// Each input item passes an input register, then the sequence matcher and a
// result register. Terminal output bytes sustain one item per cycle with one
// result each while out_ready is high. An arrow key press gives three results
// (ESC, 'O' or '[', final letter) from the result register, and the next item
// waits in the input register until the final one is taken; the result
// register's three-beat sequencer sets the order. The mode reported with an
// arrow key is the mode after all earlier output bytes.
module cursor_key_mode_tracker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_data_byte,
  input  logic [1:0] in_arrow_key,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_out_valid,
  output logic       out_last,
  output logic       out_app_cursor_mode
);
  import cktrk_pkg::*;

  logic         s1_valid_r;
  item_t        s1_item_r;
  logic         emit_ready;
  logic         s1_fire;
  mode_status_t status;

  assign s1_fire  = s1_valid_r && emit_ready;
  assign in_ready = !s1_valid_r || emit_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.op        <= in_op;
      s1_item_r.data_byte <= in_data_byte;
      s1_item_r.arrow_key <= in_arrow_key;
    end
  end

  cktrk_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_fire),
    .item   (s1_item_r),
    .status (status)
  );

  cktrk_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (s1_fire),
    .item                (s1_item_r),
    .status              (status),
    .load_ready          (emit_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_byte        (out_out_byte),
    .out_out_valid       (out_out_valid),
    .out_last            (out_last),
    .out_app_cursor_mode (out_app_cursor_mode)
  );

endmodule
